/* rtl/ppp_pkg.sv */
`timescale 1ns / 1ps

package ppp_pkg;

   // Default build parameters
   localparam int DEPTH_DEF         = 10;
   localparam int SCREEN_WIDTH_DEF  = 128;
   localparam int SCREEN_HEIGHT_DEF = 64;

   // Field widths
   localparam int HEADING_W = 9;
   localparam int RANGE_W   = 13;
   localparam int DECL_W    = 9;
   localparam int SCALE_W   = 8;
   localparam int CX_W      = 7;
   localparam int CY_W      = 6;
   localparam int MAXR_W    = 13;
   localparam int PIXX_W    = 7;
   localparam int PIXY_W    = 6;
   localparam int DOT_W     = 2;
   localparam int INDEX_W   = 6;

   // Stream and register port widths
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = CSR_ADDR_W - 2;

   // Datapath widths
   localparam int ANGLE_W = 9;
   localparam int QIDX_W  = 7;
   localparam int SINE_W  = 15;
   localparam int PROD_W  = RANGE_W + SINE_W;
   localparam int COORD_W = 14;
   localparam int NUM_W   = 15;
   localparam int DEN_W   = SCALE_W + 1;
   localparam int PIX_W   = 16;
   localparam int Q15_SHIFT = 15;

   // Register indexes
   localparam logic [REG_IDX_W-1:0] REG_DECL     = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_SCALE    = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_CENTER_X = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_CENTER_Y = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_MAX_RANGE = 3'd4;

   // Register reset values (declination is -21 in two's complement)
   localparam logic [DECL_W-1:0] DECL_RST      = 9'h1EB;
   localparam logic [SCALE_W-1:0] SCALE_RST    = 8'd20;
   localparam logic [CX_W-1:0]   CENTER_X_RST  = 7'd64;
   localparam logic [CY_W-1:0]   CENTER_Y_RST  = 6'd32;
   localparam logic [MAXR_W-1:0] MAX_RANGE_RST = 13'd4000;

   typedef struct packed {
      logic signed [DECL_W-1:0] decl;
      logic [SCALE_W-1:0]       mm_per_pixel;
      logic [CX_W-1:0]          center_x;
      logic [CY_W-1:0]          center_y;
      logic [MAXR_W-1:0]        max_range;
   } cfg_type;

   // Controller to datapath
   typedef struct packed {
      logic load_in;
      logic angle;
      logic sine;
      logic mul_x;
      logic mul_y;
      logic store;
      logic scan;
      logic read;
      logic div_start;
      logic out_load;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic point_ok;
      logic ring_empty;
      logic div_done;
      logic out_free;
      logic last_point;
   } status_type;

   typedef struct packed {
      logic              neg;
      logic [SINE_W-1:0] mag;
   } sine_type;

   // Quarter-wave sine, Q1.15, entry 90 saturated
   function automatic logic [SINE_W-1:0] quarter_sine(input logic [QIDX_W-1:0] k);
      logic [SINE_W-1:0] v;
      case (k)
         7'd0:  v = 15'd0;     7'd1:  v = 15'd572;   7'd2:  v = 15'd1144;
         7'd3:  v = 15'd1715;  7'd4:  v = 15'd2286;  7'd5:  v = 15'd2856;
         7'd6:  v = 15'd3425;  7'd7:  v = 15'd3993;  7'd8:  v = 15'd4560;
         7'd9:  v = 15'd5126;  7'd10: v = 15'd5690;  7'd11: v = 15'd6252;
         7'd12: v = 15'd6813;  7'd13: v = 15'd7371;  7'd14: v = 15'd7927;
         7'd15: v = 15'd8481;  7'd16: v = 15'd9032;  7'd17: v = 15'd9580;
         7'd18: v = 15'd10126; 7'd19: v = 15'd10668; 7'd20: v = 15'd11207;
         7'd21: v = 15'd11743; 7'd22: v = 15'd12275; 7'd23: v = 15'd12803;
         7'd24: v = 15'd13328; 7'd25: v = 15'd13848; 7'd26: v = 15'd14365;
         7'd27: v = 15'd14876; 7'd28: v = 15'd15384; 7'd29: v = 15'd15886;
         7'd30: v = 15'd16384; 7'd31: v = 15'd16877; 7'd32: v = 15'd17364;
         7'd33: v = 15'd17847; 7'd34: v = 15'd18324; 7'd35: v = 15'd18795;
         7'd36: v = 15'd19261; 7'd37: v = 15'd19720; 7'd38: v = 15'd20174;
         7'd39: v = 15'd20622; 7'd40: v = 15'd21063; 7'd41: v = 15'd21498;
         7'd42: v = 15'd21926; 7'd43: v = 15'd22348; 7'd44: v = 15'd22763;
         7'd45: v = 15'd23170; 7'd46: v = 15'd23571; 7'd47: v = 15'd23965;
         7'd48: v = 15'd24351; 7'd49: v = 15'd24730; 7'd50: v = 15'd25102;
         7'd51: v = 15'd25466; 7'd52: v = 15'd25822; 7'd53: v = 15'd26170;
         7'd54: v = 15'd26510; 7'd55: v = 15'd26842; 7'd56: v = 15'd27166;
         7'd57: v = 15'd27482; 7'd58: v = 15'd27789; 7'd59: v = 15'd28088;
         7'd60: v = 15'd28378; 7'd61: v = 15'd28660; 7'd62: v = 15'd28932;
         7'd63: v = 15'd29197; 7'd64: v = 15'd29452; 7'd65: v = 15'd29698;
         7'd66: v = 15'd29935; 7'd67: v = 15'd30163; 7'd68: v = 15'd30382;
         7'd69: v = 15'd30592; 7'd70: v = 15'd30792; 7'd71: v = 15'd30983;
         7'd72: v = 15'd31164; 7'd73: v = 15'd31336; 7'd74: v = 15'd31499;
         7'd75: v = 15'd31651; 7'd76: v = 15'd31795; 7'd77: v = 15'd31928;
         7'd78: v = 15'd32052; 7'd79: v = 15'd32166; 7'd80: v = 15'd32270;
         7'd81: v = 15'd32365; 7'd82: v = 15'd32449; 7'd83: v = 15'd32524;
         7'd84: v = 15'd32588; 7'd85: v = 15'd32643; 7'd86: v = 15'd32688;
         7'd87: v = 15'd32723; 7'd88: v = 15'd32748; 7'd89: v = 15'd32763;
         7'd90: v = 15'd32767;
         default: v = 15'd0;
      endcase
      return v;
   endfunction

   // Signed sine of a whole angle 0..359, folded onto the quarter table
   function automatic sine_type sine_of(input logic [ANGLE_W-1:0] a);
      logic [ANGLE_W-1:0] k;
      sine_type           s;
      if (a <= 9'd90) begin
         k     = a;
         s.neg = 1'b0;
      end else if (a <= 9'd180) begin
         k     = 9'd180 - a;
         s.neg = 1'b0;
      end else if (a <= 9'd270) begin
         k     = a - 9'd180;
         s.neg = 1'b1;
      end else begin
         k     = 9'd360 - a;
         s.neg = 1'b1;
      end
      s.mag = quarter_sine(k[QIDX_W-1:0]);
      return s;
   endfunction

endpackage

/* rtl/polar_point_plotter_core.sv */
`timescale 1ns / 1ps

// Polar point plotter. Each request beat carries a heading in whole degrees and a
// range in mm; the declination register is added, the range is checked against
// max_range_mm and the bad flag, and a good reading is turned into x/y in mm with a
// Q1.15 sine table and pushed into a ring of the last DEPTH points. After every
// request beat, good or not, the block sends one response beat per stored point,
// oldest first, with tlast on the newest; an empty ring sends nothing. A request
// is captured, its angle formed, its sines looked up, x and y multiplied in turn
// and the point stored; a rejected one goes straight to the scan. Each stored
// point is then read and scaled to pixels by two bit-serial dividers, one quotient
// bit per cycle, and waits for the response register to be free. The next request
// is taken only after the last point has been handed to the response register.
module polar_point_plotter_core #(
   parameter int DEPTH         = ppp_pkg::DEPTH_DEF,
   parameter int SCREEN_WIDTH  = ppp_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = ppp_pkg::SCREEN_HEIGHT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ppp_pkg::REQ_DATA_W-1:0]  req_tdata,   // heading_deg[8:0], range_mm[21:9]
   input  logic                            req_tuser,   // range_bad[0]
   // response stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ppp_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // pixel_x[6:0], pixel_y[12:7],
                                                        // dot_size[14:13], join_previous[15],
                                                        // point_index[21:16]
   output logic                            rsp_tuser,   // on_screen[0]
   output logic                            rsp_tlast,
   // register port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [ppp_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [ppp_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [ppp_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import ppp_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   ppp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   ppp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   ppp_dp #(
      .DEPTH         (DEPTH),
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* rtl/ppp_csr.sv */
`timescale 1ns / 1ps

module ppp_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [ppp_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [ppp_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [ppp_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready,
   output ppp_pkg::cfg_type                 cfg
);
   import ppp_pkg::*;

   logic [REG_IDX_W-1:0] reg_idx;
   logic                 wr_en;
   cfg_type              cfg_ff;

   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   // Register writes, access phase only
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.decl         <= DECL_RST;
         cfg_ff.mm_per_pixel <= SCALE_RST;
         cfg_ff.center_x     <= CENTER_X_RST;
         cfg_ff.center_y     <= CENTER_Y_RST;
         cfg_ff.max_range    <= MAX_RANGE_RST;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_DECL:      cfg_ff.decl         <= pwdata[DECL_W-1:0];
            REG_SCALE:     cfg_ff.mm_per_pixel <= pwdata[SCALE_W-1:0];
            REG_CENTER_X:  cfg_ff.center_x     <= pwdata[CX_W-1:0];
            REG_CENTER_Y:  cfg_ff.center_y     <= pwdata[CY_W-1:0];
            REG_MAX_RANGE: cfg_ff.max_range    <= pwdata[MAXR_W-1:0];
            default: ;
         endcase
      end
   end

   // Read mux; declination reads back sign-extended
   always_comb begin
      prdata = '0;
      unique case (reg_idx)
         REG_DECL:      prdata = {{(CSR_DATA_W-DECL_W){cfg_ff.decl[DECL_W-1]}}, cfg_ff.decl};
         REG_SCALE:     prdata = CSR_DATA_W'(cfg_ff.mm_per_pixel);
         REG_CENTER_X:  prdata = CSR_DATA_W'(cfg_ff.center_x);
         REG_CENTER_Y:  prdata = CSR_DATA_W'(cfg_ff.center_y);
         REG_MAX_RANGE: prdata = CSR_DATA_W'(cfg_ff.max_range);
         default:       prdata = '0;
      endcase
   end

endmodule

/* rtl/ppp_div.sv */
`timescale 1ns / 1ps

module ppp_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [ppp_pkg::NUM_W-1:0]   numer,
   input  logic [ppp_pkg::DEN_W-1:0]   denom,
   output logic [ppp_pkg::NUM_W-1:0]   quot,
   output logic                        done
);
   import ppp_pkg::*;

   localparam int STEP_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0]  quo_ff;
   logic [DEN_W-1:0]  rem_ff;
   logic [DEN_W-1:0]  den_ff;
   logic [STEP_W-1:0] step_ff;
   logic              done_ff;
   logic [DEN_W:0]    trial;
   logic [DEN_W:0]    trial_sub;
   logic              fits;

   // One restoring step per cycle, dividend bits enter from the top
   assign trial     = {rem_ff, quo_ff[NUM_W-1]};
   assign trial_sub = trial - {1'b0, den_ff};
   assign fits      = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         done_ff <= 1'b0;
      end else if (start) begin
         step_ff <= STEP_W'(NUM_W);
         done_ff <= 1'b0;
      end else if (step_ff != '0) begin
         step_ff <= step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= numer;
         rem_ff <= '0;
         den_ff <= denom;
      end else if (step_ff != '0) begin
         rem_ff <= fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_ff <= {quo_ff[NUM_W-2:0], fits};
      end
   end

   assign quot = quo_ff;
   assign done = done_ff;

endmodule

/* rtl/ppp_ctrl.sv */
`timescale 1ns / 1ps

module ppp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ppp_pkg::status_type  status,
   output ppp_pkg::cmd_type     cmd
);
   import ppp_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE  = 10'b00_0000_0001,
      S_ANGLE = 10'b00_0000_0010,
      S_SINE  = 10'b00_0000_0100,
      S_MULX  = 10'b00_0000_1000,
      S_MULY  = 10'b00_0001_0000,
      S_STORE = 10'b00_0010_0000,
      S_SCAN  = 10'b00_0100_0000,
      S_READ  = 10'b00_1000_0000,
      S_DIVGO = 10'b01_0000_0000,
      S_DIV   = 10'b10_0000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sequencer: capture, convert and store a good reading, then walk the ring oldest first
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = S_ANGLE;
            end
         end
         S_ANGLE: begin
            cmd.angle = 1'b1;
            state_in  = status.point_ok ? S_SINE : S_SCAN;
         end
         S_SINE: begin
            cmd.sine = 1'b1;
            state_in = S_MULX;
         end
         S_MULX: begin
            cmd.mul_x = 1'b1;
            state_in  = S_MULY;
         end
         S_MULY: begin
            cmd.mul_y = 1'b1;
            state_in  = S_STORE;
         end
         S_STORE: begin
            cmd.store = 1'b1;
            state_in  = S_SCAN;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            state_in = status.ring_empty ? S_IDLE : S_READ;
         end
         S_READ: begin
            cmd.read = 1'b1;
            state_in = S_DIVGO;
         end
         S_DIVGO: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (status.div_done && status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = status.last_point ? S_IDLE : S_READ;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

/* rtl/ppp_dp.sv */
`timescale 1ns / 1ps

module ppp_dp #(
   parameter int DEPTH         = ppp_pkg::DEPTH_DEF,
   parameter int SCREEN_WIDTH  = ppp_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = ppp_pkg::SCREEN_HEIGHT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ppp_pkg::cfg_type                  cfg,
   input  ppp_pkg::cmd_type                  cmd,
   output ppp_pkg::status_type               status,
   input  logic [ppp_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                              req_tuser,
   input  logic                              rsp_tready,
   output logic                              rsp_tvalid,
   output logic [ppp_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tuser,
   output logic                              rsp_tlast
);
   import ppp_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = PTR_W + 2;
   localparam logic [PTR_W-1:0] LAST_SLOT  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);
   localparam logic signed [PIX_W-1:0] SCR_W = PIX_W'(SCREEN_WIDTH);
   localparam logic signed [PIX_W-1:0] SCR_H = PIX_W'(SCREEN_HEIGHT);
   localparam logic [PROD_W:0] Q15_HALF = (PROD_W + 1)'(1 << (Q15_SHIFT - 1));

   function automatic logic [PTR_W-1:0] slot_next(input logic [PTR_W-1:0] p);
      return (p == LAST_SLOT) ? '0 : p + 1'b1;
   endfunction

   // Captured input beat
   logic [HEADING_W-1:0] heading_ff;
   logic [RANGE_W-1:0]   range_ff;
   logic                 bad_ff;

   // Conversion pipeline
   logic signed [10:0]   angle_sum;
   logic signed [10:0]   angle_wrap;
   logic [ANGLE_W-1:0]   angle_ff;
   logic [9:0]           ax_sum;
   logic [9:0]           ax_wrap;
   sine_type             sin_x;
   sine_type             sin_y;
   sine_type             sin_x_ff;
   sine_type             sin_y_ff;
   logic [PROD_W-1:0]    prod_ff;
   logic                 prod_neg_ff;
   logic [PROD_W:0]      prod_bias;
   logic [COORD_W-1:0]   prod_q;
   logic [COORD_W-1:0]   prod_round;
   logic [COORD_W-1:0]   x_mm_ff;

   // Ring of points and its pointers
   logic [2*COORD_W-1:0] ring_mem [DEPTH];
   logic [2*COORD_W-1:0] rd_data_ff;
   logic [PTR_W-1:0]     write_ptr_ff;
   logic [PTR_W-1:0]     oldest_ptr_ff;
   logic [PTR_W-1:0]     rd_ptr_ff;
   logic [PTR_W-1:0]     idx_ff;
   logic [CNT_W-1:0]     count_ff;

   // Pixel mapping
   logic [SCALE_W-1:0]   scale;
   logic [DEN_W-1:0]     den;
   logic [COORD_W-1:0]   rd_x;
   logic [COORD_W-1:0]   rd_y;
   logic [COORD_W-1:0]   mag_x;
   logic [COORD_W-1:0]   mag_y;
   logic [NUM_W-1:0]     num_x;
   logic [NUM_W-1:0]     num_y;
   logic [NUM_W-1:0]     quot_x;
   logic [NUM_W-1:0]     quot_y;
   logic                 done_x;
   logic                 done_y;
   logic                 sign_x_ff;
   logic                 sign_y_ff;
   logic signed [PIX_W-1:0] qx_s;
   logic signed [PIX_W-1:0] qy_s;
   logic signed [PIX_W-1:0] off_x;
   logic signed [PIX_W-1:0] off_y;
   logic signed [PIX_W-1:0] px;
   logic signed [PIX_W-1:0] py;
   logic                 on_screen;
   logic [PIXX_W-1:0]    pix_x;
   logic [PIXY_W-1:0]    pix_y;
   logic                 dot_hi;
   logic [DOT_W-1:0]     dot_size;
   logic                 join_prev;
   logic                 last_point;

   // Result register
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                  rsp_user_ff;
   logic                  rsp_last_ff;

   // Input capture
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         heading_ff <= req_tdata[HEADING_W-1:0];
         range_ff   <= req_tdata[HEADING_W +: RANGE_W];
         bad_ff     <= req_tuser;
      end
   end

   // Heading plus declination, wrapped into 0..359
   assign angle_sum = $signed({2'b00, heading_ff}) + $signed({{2{cfg.decl[DECL_W-1]}}, cfg.decl});

   always_comb begin
      if (angle_sum < 0) begin
         angle_wrap = angle_sum + 11'sd360;
      end else if (angle_sum >= 11'sd720) begin
         angle_wrap = angle_sum - 11'sd720;
      end else if (angle_sum >= 11'sd360) begin
         angle_wrap = angle_sum - 11'sd360;
      end else begin
         angle_wrap = angle_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.angle) begin
         angle_ff <= angle_wrap[ANGLE_W-1:0];
      end
   end

   // Sine lookups: cosine via a quarter turn ahead
   assign ax_sum  = {1'b0, angle_ff} + 10'd90;
   assign ax_wrap = (ax_sum >= 10'd360) ? ax_sum - 10'd360 : ax_sum;
   assign sin_x   = sine_of(ax_wrap[ANGLE_W-1:0]);
   assign sin_y   = sine_of(angle_ff);

   always_ff @(posedge clock) begin
      if (cmd.sine) begin
         sin_x_ff <= sin_x;
         sin_y_ff <= sin_y;
      end
   end

   // Shared multiplier, x then y; Q1.15 product rounded half away from zero
   assign prod_bias  = {1'b0, prod_ff} + Q15_HALF;
   assign prod_q     = prod_bias[Q15_SHIFT +: COORD_W];
   assign prod_round = prod_neg_ff ? -prod_q : prod_q;

   always_ff @(posedge clock) begin
      if (cmd.mul_x) begin
         prod_ff     <= PROD_W'(range_ff) * PROD_W'(sin_x_ff.mag);
         prod_neg_ff <= sin_x_ff.neg;
      end else if (cmd.mul_y) begin
         prod_ff     <= PROD_W'(range_ff) * PROD_W'(sin_y_ff.mag);
         prod_neg_ff <= sin_y_ff.neg;
         x_mm_ff     <= prod_round;
      end
   end

   // Point ring
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         ring_mem[write_ptr_ff] <= {x_mm_ff, prod_round};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd_data_ff <= ring_mem[rd_ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_ptr_ff  <= '0;
         oldest_ptr_ff <= '0;
         count_ff      <= '0;
      end else if (cmd.store) begin
         write_ptr_ff <= slot_next(write_ptr_ff);
         if (count_ff != FULL_COUNT) begin
            count_ff <= count_ff + 1'b1;
         end else begin
            oldest_ptr_ff <= slot_next(oldest_ptr_ff);
         end
      end
   end

   // Scan position, oldest first
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         idx_ff    <= '0;
      end else if (cmd.scan) begin
         rd_ptr_ff <= oldest_ptr_ff;
         idx_ff    <= '0;
      end else if (cmd.out_load) begin
         rd_ptr_ff <= slot_next(rd_ptr_ff);
         idx_ff    <= idx_ff + 1'b1;
      end
   end

   // Divider operands: round(|v| / s) as (2|v| + s) / 2s
   assign scale = (cfg.mm_per_pixel == '0) ? SCALE_W'(1) : cfg.mm_per_pixel;
   assign den   = {scale, 1'b0};
   assign rd_x  = rd_data_ff[COORD_W +: COORD_W];
   assign rd_y  = rd_data_ff[COORD_W-1:0];
   assign mag_x = rd_x[COORD_W-1] ? -rd_x : rd_x;
   assign mag_y = rd_y[COORD_W-1] ? -rd_y : rd_y;
   assign num_x = {mag_x, 1'b0} + NUM_W'(scale);
   assign num_y = {mag_y, 1'b0} + NUM_W'(scale);

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         sign_x_ff <= rd_x[COORD_W-1];
         sign_y_ff <= rd_y[COORD_W-1];
      end
   end

   ppp_div u_div_x (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .numer (num_x),
      .denom (den),
      .quot  (quot_x),
      .done  (done_x)
   );

   ppp_div u_div_y (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .numer (num_y),
      .denom (den),
      .quot  (quot_y),
      .done  (done_y)
   );

   // Screen position and per-point flags
   assign qx_s  = PIX_W'(quot_x);
   assign qy_s  = PIX_W'(quot_y);
   assign off_x = sign_x_ff ? -qx_s : qx_s;
   assign off_y = sign_y_ff ? -qy_s : qy_s;
   assign px    = $signed(PIX_W'(cfg.center_x)) + off_x;
   assign py    = $signed(PIX_W'(cfg.center_y)) - off_y;

   assign on_screen  = (px >= 0) && (px < SCR_W) && (py >= 0) && (py < SCR_H);
   assign pix_x      = on_screen ? px[PIXX_W-1:0] : '0;
   assign pix_y      = on_screen ? py[PIXY_W-1:0] : '0;
   assign dot_hi     = CMP_W'({idx_ff, 1'b0}) >= CMP_W'(count_ff);
   assign dot_size   = dot_hi ? DOT_W'(2) : DOT_W'(1);
   assign join_prev  = on_screen && (idx_ff != '0);
   assign last_point = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;

   // Result register: holds one beat while the next point is worked on
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff <= {2'b00, INDEX_W'(idx_ff), join_prev, dot_size, pix_y, pix_x};
         rsp_user_ff <= on_screen;
         rsp_last_ff <= last_point;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign status.point_ok   = !bad_ff && (range_ff != '0) && (range_ff < cfg.max_range);
   assign status.ring_empty = (count_ff == '0);
   assign status.div_done   = done_x && done_y;
   assign status.out_free   = !rsp_valid_ff || rsp_tready;
   assign status.last_point = last_point;

   // A loaded beat never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten");

   // Until the ring fills, oldest stays at slot 0 and write tracks the count
   a_fill_order: assert property (@(posedge clock) disable iff (reset)
      (count_ff < FULL_COUNT) |-> (oldest_ptr_ff == '0 && write_ptr_ff == PTR_W'(count_ff)))
      else $error("ring pointers out of step while filling");

   // Once full, the next write lands on the oldest entry
   a_full_order: assert property (@(posedge clock) disable iff (reset)
      (count_ff == FULL_COUNT) |-> (oldest_ptr_ff == write_ptr_ff))
      else $error("ring pointers out of step while full");

   // Only stored points are sent
   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (CNT_W'(idx_ff) < count_ff))
      else $error("point index beyond stored count");

endmodule
